// File: sv/assert_macros.svh
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/hmf_pkg.sv
// Shared constants, state encoding and control structs for the histogram mode finder.
package hmf_pkg;

    localparam int unsigned MAX_PIXELS = 1048576;
    localparam int unsigned LEVELS     = 256;

    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned COUNT_W    = 21;
    localparam int unsigned BIN_STORE  = 256;
    localparam int unsigned IDX_W      = $clog2(BIN_STORE);

    // Bin saturation value: MAX_PIXELS unless it does not fit a bin.
    localparam logic [COUNT_W-1:0] BIN_CAP =
        (MAX_PIXELS > ((1 << COUNT_W) - 1)) ? COUNT_W'((1 << COUNT_W) - 1)
                                             : COUNT_W'(MAX_PIXELS);

    // Highest level that owns a bin; larger levels fold into it.
    localparam logic [LEVEL_W-1:0] LEVEL_TOP =
        (LEVELS > BIN_STORE) ? LEVEL_W'(BIN_STORE - 1)
                             : ((LEVELS < 1) ? LEVEL_W'(0) : LEVEL_W'(LEVELS - 1));

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BIN_STORE - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } hmf_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;   // latch request, read its bin
        logic bump;      // write incremented bin back
        logic sweep;     // read bin at index, write zero there, advance index
        logic cmp_arm;   // bin read by this sweep enters the max search
        logic best_init; // reset the running maximum
    } hmf_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic idx_last;  // sweep index at final bin
        logic last_flag; // current request is the final pixel
    } hmf_status_t;

endpackage

// File: sv/hmf_ram.sv
// Generic single-write, single-read RAM with registered read (old data on collision).
module hmf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/hmf_datapath.sv
// Datapath: bin store, request latch, sweep index and running maximum.
module hmf_datapath import hmf_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  hmf_cmd_t            cmd,
    output hmf_status_t         status,
    input  logic [LEVEL_W-1:0]  pixel_level,
    input  logic                last_pixel,
    output logic [LEVEL_W-1:0]  mode_level,
    output logic [COUNT_W-1:0]  mode_count
);

    logic [LEVEL_W-1:0] level_reg;
    logic               last_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_level_reg;
    logic [LEVEL_W-1:0] best_level_reg;
    logic [COUNT_W-1:0] best_count_reg;

    logic [LEVEL_W-1:0] level_clamped;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [COUNT_W-1:0] ram_rdata;
    logic [COUNT_W-1:0] bin_inc;

    // Fold out-of-range levels onto the top bin
    assign level_clamped = (pixel_level > LEVEL_TOP) ? LEVEL_TOP : pixel_level;

    // Saturating increment of the bin read at capture
    assign bin_inc = (ram_rdata < BIN_CAP) ? ram_rdata + COUNT_W'(1) : ram_rdata;

    // Store port muxing: capture reads the new level, sweep reads and zeroes the index
    always_comb
    begin
        ram_raddr = cmd.capture ? IDX_W'(level_clamped) : idx_reg;
        ram_we    = cmd.bump | cmd.sweep;
        ram_waddr = cmd.bump ? IDX_W'(level_reg) : idx_reg;
        ram_wdata = cmd.bump ? bin_inc : '0;
    end

    hmf_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BIN_STORE)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            level_reg <= level_clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            last_reg <= last_pixel;
        end
    end

    // Sweep index wraps back to zero after the final bin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // Read data of a sweep arrives in the next cycle; track which level it is
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.sweep & cmd.cmp_arm & (LEVEL_W'(idx_reg) <= LEVEL_TOP);
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_level_reg <= idx_reg;
    end

    // Running maximum; strictly greater keeps the lowest level on ties
    always_ff @(posedge clk)
    begin
        if (cmd.best_init)
        begin
            best_level_reg <= '0;
            best_count_reg <= '0;
        end
        else if (cmp_valid_reg && (ram_rdata > best_count_reg))
        begin
            best_level_reg <= LEVEL_W'(cmp_level_reg);
            best_count_reg <= ram_rdata;
        end
    end

    assign status.idx_last  = (idx_reg == IDX_LAST);
    assign status.last_flag = last_reg;
    assign mode_level       = best_level_reg;
    assign mode_count       = best_count_reg;

endmodule

// File: sv/hmf_ctrl.sv
// Controller: sequences clear pass, bin update, scan-and-clear and result strobe.
module hmf_ctrl import hmf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  hmf_status_t status,
    output hmf_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    hmf_state_t state_reg;
    hmf_state_t state_next;

    // State register; reset enters the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.bump = 1'b1;
                if (status.last_flag)
                begin
                    cmd.best_init = 1'b1;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.sweep   = 1'b1;
                cmd.cmp_arm = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/histogram_mode_finder.sv
// Histogram mode finder: each pixel request reads its bin, then writes it back before the next
// request is taken. Last pixel: result strobe on done after the request is accepted, through
// the update, a scan of all 256 bins that also zeroes each bin, a compare step and a result step.
// Reset clears the bin store in a pass over all 256 bins; busy stays high until it ends.
// done lasts one cycle and the receiver cannot stall it.
module histogram_mode_finder import hmf_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [LEVEL_W-1:0] pixel_level,
    input  logic               last_pixel,
    output logic               busy,
    output logic               done,
    output logic [LEVEL_W-1:0] mode_level,
    output logic [COUNT_W-1:0] mode_count
);

`include "assert_macros.svh"

    hmf_cmd_t    cmd;
    hmf_status_t status;

    hmf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    hmf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .pixel_level (pixel_level),
        .last_pixel  (last_pixel),
        .mode_level  (mode_level),
        .mode_count  (mode_count)
    );

    // Checks
    `ASSERT_CLK(a_done_single, done |=> !done, "done held for more than one cycle")
    `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
    `ASSERT_CLK(a_done_then_idle, done |=> !busy, "block not idle after result")
    `ASSERT_CLK(a_count_cap, done |-> (mode_count <= BIN_CAP), "mode count above bin cap")
    `ASSERT_CLK(a_done_busy, done |-> busy, "result strobe while idle")

endmodule

// File: tb/sv/histogram_mode_finder_tb.sv
// Self-checking testbench for the histogram mode finder: directed images, then random images.
module histogram_mode_finder_tb;
    import hmf_pkg::*;

    localparam int unsigned RANDOM_PIXELS = 1850;
    localparam int unsigned DRAIN_CYCLES  = 300;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] count;
    } mode_result_t;

    // One directed request; a typed row carries its own expected mode.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               last;
        logic               typed;
        logic [LEVEL_W-1:0] exp_level;
        logic [COUNT_W-1:0] exp_count;
    } pixel_row_t;

    localparam int unsigned NUM_ROWS = 20;

    localparam pixel_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // single black pixel, single white pixel
        '{8'd0,   1'b1, 1'b1, 8'd0,   21'd1},
        '{8'd255, 1'b1, 1'b1, 8'd255, 21'd1},
        // tie of two levels: the lower one wins
        '{8'd7,   1'b0, 1'b0, 8'd0,   21'd0},
        '{8'd3,   1'b1, 1'b1, 8'd3,   21'd1},
        // top level dominates
        '{8'd255, 1'b0, 1'b0, 8'd0,   21'd0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   21'd0},
        '{8'd0,   1'b1, 1'b1, 8'd255, 21'd2},
        // tie between both extremes
        '{8'd0,   1'b0, 1'b0, 8'd0,   21'd0},
        '{8'd255, 1'b1, 1'b1, 8'd0,   21'd1},
        // alternating bit patterns, tied
        '{8'd170, 1'b0, 1'b0, 8'd0,   21'd0},
        '{8'd85,  1'b0, 1'b0, 8'd0,   21'd0},
        '{8'd85,  1'b0, 1'b0, 8'd0,   21'd0},
        '{8'd170, 1'b1, 1'b0, 8'd0,   21'd0},
        // bins must start empty for the next image
        '{8'd170, 1'b1, 1'b1, 8'd170, 21'd1},
        // mixed image
        '{8'd12,  1'b0, 1'b0, 8'd0,   21'd0},
        '{8'd200, 1'b0, 1'b0, 8'd0,   21'd0},
        '{8'd12,  1'b0, 1'b0, 8'd0,   21'd0},
        '{8'd99,  1'b0, 1'b0, 8'd0,   21'd0},
        '{8'd200, 1'b0, 1'b0, 8'd0,   21'd0},
        '{8'd12,  1'b1, 1'b0, 8'd0,   21'd0}
    };

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [LEVEL_W-1:0] pixel_level;
    logic               last_pixel;
    logic               busy;
    logic               done;
    logic [LEVEL_W-1:0] mode_level;
    logic [COUNT_W-1:0] mode_count;

    // Predictor state and the queue of modes still to come
    logic [COUNT_W-1:0] level_bins [BIN_STORE];
    mode_result_t       pending_modes [$];

    int unsigned error_count;
    int unsigned pixels_sent;
    int unsigned images_sent;
    int unsigned modes_checked;
    int unsigned random_pixels;
    bit          no_gap;

    histogram_mode_finder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .pixel_level (pixel_level),
        .last_pixel  (last_pixel),
        .busy        (busy),
        .done        (done),
        .mode_level  (mode_level),
        .mode_count  (mode_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Count one pixel into its bin; on the last pixel scan for the mode and clear
    task automatic tally_pixel(input logic [LEVEL_W-1:0] lvl, input logic lst,
                               output bit found, output mode_result_t mode);
        found = 1'b0;
        mode  = '0;
        if (level_bins[lvl] < BIN_CAP)
        begin
            level_bins[lvl] = level_bins[lvl] + 1'b1;
        end
        if (lst)
        begin
            found      = 1'b1;
            mode.count = level_bins[0];
            for (int k = 1; k < BIN_STORE; k++)
            begin
                if (level_bins[k] > mode.count)
                begin
                    mode.count = level_bins[k];
                    mode.level = LEVEL_W'(k);
                end
            end
            for (int k = 0; k < BIN_STORE; k++)
            begin
                level_bins[k] = '0;
            end
        end
    endtask

    // Drive one pixel request after a random gap, wait for acceptance, then predict
    task automatic send_pixel(input logic [LEVEL_W-1:0] lvl, input logic lst,
                              input logic use_typed, input mode_result_t typed_mode);
        int unsigned  gap;
        bit           found;
        mode_result_t mode;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap > 0)
        begin
            start       <= 1'b0;
            pixel_level <= LEVEL_W'($urandom);
            last_pixel  <= 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        pixel_level <= lvl;
        last_pixel  <= lst;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pixels_sent++;
        tally_pixel(lvl, lst, found, mode);
        if (found)
        begin
            images_sent++;
            pending_modes.push_back(use_typed ? typed_mode : mode);
        end
    endtask

    // One random image: size and level pattern drawn per image
    task automatic run_random_image();
        int unsigned        n;
        int unsigned        kind;
        int unsigned        size_pick;
        logic [LEVEL_W-1:0] palette [4];
        logic [LEVEL_W-1:0] lvl;
        kind      = $urandom_range(0, 9);
        size_pick = $urandom_range(0, 19);
        if (size_pick < 14)
            n = $urandom_range(1, 24);
        else if (size_pick < 19)
            n = $urandom_range(25, 80);
        else
            n = $urandom_range(200, 400);
        // keep the total close to the planned pixel count
        if (n > RANDOM_PIXELS - random_pixels)
            n = RANDOM_PIXELS - random_pixels;
        for (int p = 0; p < 4; p++)
        begin
            palette[p] = LEVEL_W'($urandom);
        end
        // alternating two-level images need an even size to end in a tie
        if (kind >= 8)
            n = 2 * ((n + 1) / 2);
        no_gap = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (kind <= 2)
                lvl = LEVEL_W'($urandom);
            else if (kind <= 5)
                lvl = palette[$urandom_range(0, 3)];
            else if (kind <= 7)
                lvl = ($urandom_range(0, 2) == 0) ? LEVEL_W'($urandom) : palette[0];
            else
                lvl = (i % 2 == 0) ? palette[1] : palette[0];
            send_pixel(lvl, (i == n - 1), 1'b0, '0);
            random_pixels++;
        end
        no_gap = 1'b0;
    endtask

    // Result checker: every done pulse must match the oldest pending mode
    always @(posedge clk)
    begin
        mode_result_t want;
        if (rst_n && done)
        begin
            if (pending_modes.size() == 0)
            begin
                report_mismatch("unexpected result, level", mode_level, 0);
            end
            else
            begin
                want = pending_modes.pop_front();
                modes_checked++;
                if (mode_level !== want.level)
                    report_mismatch("mode_level", mode_level, want.level);
                if (mode_count !== want.count)
                    report_mismatch("mode_count", mode_count, want.count);
            end
        end
    end

    // Run limit, well above the slowest legal run
    initial
    begin
        #30000000;
        $display("Timeout with %0d modes still pending", pending_modes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main sequence
    initial
    begin
        mode_result_t typed_mode;
        error_count   = 0;
        pixels_sent   = 0;
        images_sent   = 0;
        modes_checked = 0;
        random_pixels = 0;
        no_gap        = 1'b0;
        for (int k = 0; k < BIN_STORE; k++)
        begin
            level_bins[k] = '0;
        end
        rst_n       = 1'b0;
        start       = 1'b0;
        pixel_level = '0;
        last_pixel  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed images
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            typed_mode.level = DIRECTED_ROWS[r].exp_level;
            typed_mode.count = DIRECTED_ROWS[r].exp_count;
            send_pixel(DIRECTED_ROWS[r].level, DIRECTED_ROWS[r].last,
                       DIRECTED_ROWS[r].typed, typed_mode);
        end

        // Random images
        while (random_pixels < RANDOM_PIXELS)
        begin
            run_random_image();
        end
        @(negedge clk);
        start <= 1'b0;

        // Drain outstanding results, then let the block settle
        while (pending_modes.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels in %0d images; %0d mode results checked.",
                 pixels_sent, images_sent, modes_checked);
        $display("Images covered ties, single pixels, both level extremes and bursts.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/hmf_pkg.sv
sv/hmf_ram.sv
sv/hmf_datapath.sv
sv/hmf_ctrl.sv
sv/histogram_mode_finder.sv
tb/sv/histogram_mode_finder_tb.sv
